[src/miller_rabin_prime_test_assert.svh]
// ----------------------------------------------------------------------------
// Miller-Rabin prime test assertion macros
// Short forms for the concurrent assertions of the checker module.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIME_TEST_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_ASSERT_SVH

// Overlapping implication: the consequent is checked at the same edge.
`define MRPT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: the consequent is checked at the next edge.
`define MRPT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mrpt_pkg.sv]
// ----------------------------------------------------------------------------
// Miller-Rabin prime test package
// Shared constants, the table of witness bases and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package mrpt_pkg;

  // Default width of the tested value.
  localparam int unsigned DEF_WIDTH = 62;

  // Witness bases, tested in this order.
  localparam int unsigned NUM_BASES  = 9;
  localparam int unsigned BASE_IDX_W = $clog2(NUM_BASES);
  localparam int unsigned BASE_W     = 5;

  localparam logic [BASE_W-1:0] BASE_TABLE [NUM_BASES] = '{
    5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23
  };

  localparam logic [BASE_IDX_W-1:0] LAST_BASE_IDX = BASE_IDX_W'(NUM_BASES - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPLIT,
    S_BASE,
    S_REDUCE,
    S_POW,
    S_POW_MUL,
    S_POW_SQR,
    S_CHECK,
    S_SQ,
    S_SQ_WAIT,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[src/mrpt_split.sv]
// ----------------------------------------------------------------------------
// Power-of-two splitter
// Writes a nonzero value as d * 2^r with d odd, one shift per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_split #(
  parameter int unsigned WIDTH = mrpt_pkg::DEF_WIDTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [WIDTH-1:0]          v_i,
  output logic                           done_o,
  output logic [WIDTH-1:0]               d_o,
  output logic [$clog2(WIDTH)-1:0]       r_o
);

  localparam int unsigned RW = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH-1:0] v_q, v_d;
  logic [RW-1:0]    r_q, r_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    v_d    = v_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      v_d    = v_i;
      r_d    = '0;
    end else if (busy_q) begin
      // Keep shifting while the low bit is clear.
      if ((v_q != '0) && !v_q[0]) begin
        v_d = v_q >> 1;
        r_d = r_q + RW'(1);
      end else begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign d_o    = v_q;
  assign r_o    = r_q;

endmodule

`default_nettype wire

[src/mrpt_mulmod.sv]
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Shift-and-add product x * y mod m, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_mulmod #(
  parameter int unsigned WIDTH = mrpt_pkg::DEF_WIDTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] x_i,
  input  wire logic [WIDTH-1:0] y_i,
  input  wire logic [WIDTH-1:0] m_i,
  output logic                  done_o,
  output logic [WIDTH-1:0]      p_o
);

  // (a + b) mod m for a, b below m; the sum carries one extra bit.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0]   s;
    logic [WIDTH+1:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = {1'b0, s} - {2'b00, m};
    return t[WIDTH+1] ? s[WIDTH-1:0] : t[WIDTH-1:0];
  endfunction

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    if (start_i) begin
      busy_d = 1'b1;
      acc_d  = '0;
      x_d    = x_i;
      y_d    = y_i;
    end else if (busy_q) begin
      if (y_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (y_q[0]) begin
          acc_d = add_mod(acc_q, x_q, m_i);
        end
        x_d = add_mod(x_q, x_q, m_i);
        y_d = y_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

`default_nettype wire

[src/miller_rabin_prime_test.sv]
// Work per item: one modular multiplication steps through the bits of its multiplier, and
// a base needs one or two multiplications per exponent bit plus up to r - 1 squarings,
// repeated for each base in turn while the item is still undecided.
// Throughput: one item at a time, paced by the shared bit-serial multiplier.
// Reset: asynchronous and active low; it clears the controller and the output valid.
// ----------------------------------------------------------------------------
// Miller-Rabin prime test
// Deterministic primality test with the bases 2 to 23 over a WIDTH-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module miller_rabin_prime_test #(
  parameter int unsigned WIDTH = mrpt_pkg::DEF_WIDTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [WIDTH-1:0] n_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  is_prime_o
);

  localparam int unsigned RW = $clog2(WIDTH);

  mrpt_pkg::state_e state_q, state_d;

  // Item registers. The value under test and n - 1 stay put for the whole item.
  logic [WIDTH-1:0] n_q, n_d;
  logic [WIDTH-1:0] nm1_q, nm1_d;
  // Current base, later the running square of the base during exponentiation.
  logic [WIDTH-1:0] a_q, a_d;
  // Running power; after exponentiation it is the witness value x.
  logic [WIDTH-1:0] res_q, res_d;
  // Exponent bits still to be consumed, low bit first.
  logic [WIDTH-1:0] e_q, e_d;
  logic [RW-1:0]    k_q, k_d;
  logic [mrpt_pkg::BASE_IDX_W-1:0] bi_q, bi_d;
  logic             verdict_q, verdict_d;

  logic out_valid_q, out_valid_d;
  logic is_prime_q, is_prime_d;
  logic out_load;

  // Shared units.
  logic             split_start;
  logic             split_done;
  logic [WIDTH-1:0] split_d;
  logic [RW-1:0]    split_r;
  logic [WIDTH-1:0] n_minus_one;

  logic             mm_start;
  logic             mm_done;
  logic [WIDTH-1:0] mm_x;
  logic [WIDTH-1:0] mm_y;
  logic [WIDTH-1:0] mm_p;

  logic [WIDTH-1:0] base_ext;
  logic             base_pass;

  assign n_minus_one = n_i - WIDTH'(1);
  assign base_ext    = WIDTH'(mrpt_pkg::BASE_TABLE[bi_q]);

  mrpt_split #(
    .WIDTH(WIDTH)
  ) u_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(split_start),
    .v_i    (n_minus_one),
    .done_o (split_done),
    .d_o    (split_d),
    .r_o    (split_r)
  );

  mrpt_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .x_i    (mm_x),
    .y_i    (mm_y),
    .m_i    (n_q),
    .done_o (mm_done),
    .p_o    (mm_p)
  );

  // The controller walks the bases in order. For each base it checks for
  // n equal to the base, reduces the base below n, forms base^d mod n by
  // right-to-left square and multiply, and then squares up to r - 1 times
  // looking for n - 1. A base that fails ends the item as composite.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    nm1_d       = nm1_q;
    a_d         = a_q;
    res_d       = res_q;
    e_d         = e_q;
    k_d         = k_q;
    bi_d        = bi_q;
    verdict_d   = verdict_q;
    split_start = 1'b0;
    mm_start    = 1'b0;
    mm_x        = a_q;
    mm_y        = a_q;
    base_pass   = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      mrpt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          n_d   = n_i;
          nm1_d = n_minus_one;
          // Zero and one are not prime and need no further work.
          if (n_i[WIDTH-1:1] == '0) begin
            verdict_d = 1'b0;
            state_d   = mrpt_pkg::S_DONE;
          end else begin
            split_start = 1'b1;
            state_d     = mrpt_pkg::S_SPLIT;
          end
        end
      end

      mrpt_pkg::S_SPLIT: begin
        if (split_done) begin
          bi_d    = '0;
          state_d = mrpt_pkg::S_BASE;
        end
      end

      mrpt_pkg::S_BASE: begin
        if (n_q == base_ext) begin
          verdict_d = 1'b1;
          state_d   = mrpt_pkg::S_DONE;
        end else begin
          a_d     = base_ext;
          state_d = mrpt_pkg::S_REDUCE;
        end
      end

      mrpt_pkg::S_REDUCE: begin
        // Only a tiny n can lie below a base; a few subtractions reduce it.
        if (a_q >= n_q) begin
          a_d = a_q - n_q;
        end else begin
          res_d   = WIDTH'(1);
          e_d     = split_d;
          state_d = mrpt_pkg::S_POW;
        end
      end

      mrpt_pkg::S_POW: begin
        if (e_q == '0) begin
          state_d = mrpt_pkg::S_CHECK;
        end else if (e_q[0]) begin
          mm_start = 1'b1;
          mm_x     = res_q;
          mm_y     = a_q;
          state_d  = mrpt_pkg::S_POW_MUL;
        end else begin
          mm_start = 1'b1;
          state_d  = mrpt_pkg::S_POW_SQR;
        end
      end

      mrpt_pkg::S_POW_MUL: begin
        if (mm_done) begin
          res_d    = mm_p;
          mm_start = 1'b1;
          state_d  = mrpt_pkg::S_POW_SQR;
        end
      end

      mrpt_pkg::S_POW_SQR: begin
        if (mm_done) begin
          a_d     = mm_p;
          e_d     = e_q >> 1;
          state_d = mrpt_pkg::S_POW;
        end
      end

      mrpt_pkg::S_CHECK: begin
        if ((res_q == WIDTH'(1)) || (res_q == nm1_q)) begin
          base_pass = 1'b1;
        end else begin
          k_d     = RW'(1);
          state_d = mrpt_pkg::S_SQ;
        end
      end

      mrpt_pkg::S_SQ: begin
        if (k_q >= split_r) begin
          verdict_d = 1'b0;
          state_d   = mrpt_pkg::S_DONE;
        end else begin
          mm_start = 1'b1;
          mm_x     = res_q;
          mm_y     = res_q;
          state_d  = mrpt_pkg::S_SQ_WAIT;
        end
      end

      mrpt_pkg::S_SQ_WAIT: begin
        if (mm_done) begin
          res_d = mm_p;
          k_d   = k_q + RW'(1);
          if (mm_p == nm1_q) begin
            base_pass = 1'b1;
          end else begin
            state_d = mrpt_pkg::S_SQ;
          end
        end
      end

      mrpt_pkg::S_DONE: begin
        // Hand the verdict to the output register once it is free.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = mrpt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = mrpt_pkg::S_IDLE;
      end
    endcase

    // A passing base moves on to the next one, or ends the item as prime.
    if (base_pass) begin
      if (bi_q == mrpt_pkg::LAST_BASE_IDX) begin
        verdict_d = 1'b1;
        state_d   = mrpt_pkg::S_DONE;
      end else begin
        bi_d    = bi_q + mrpt_pkg::BASE_IDX_W'(1);
        state_d = mrpt_pkg::S_BASE;
      end
    end
  end

  // The output register holds a result until it is taken.
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);
  assign is_prime_d  = out_load ? verdict_q : is_prime_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrpt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    nm1_q      <= nm1_d;
    a_q        <= a_d;
    res_q      <= res_d;
    e_q        <= e_d;
    k_q        <= k_d;
    bi_q       <= bi_d;
    verdict_q  <= verdict_d;
    is_prime_q <= is_prime_d;
  end

  // A new item is taken only while the controller is idle.
  assign in_stall_o  = (state_q != mrpt_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

endmodule

`default_nettype wire

[src/mrpt_checker.sv]
// ----------------------------------------------------------------------------
// Miller-Rabin prime test checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "miller_rabin_prime_test_assert.svh"

module mrpt_checker #(
  parameter int unsigned WIDTH = mrpt_pkg::DEF_WIDTH
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic [WIDTH-1:0] n_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic             is_prime_o
);

  // A stalled result stays valid and unchanged.
  `MRPT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(is_prime_o), "stalled result changed")

  // The block works on one item at a time.
  `MRPT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after an accepted item")

  // A result appears only as the block finishes an item.
  `MRPT_ASSERT_IMP(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result appeared while idle")

  // Zero and one, taken while no result is waiting, come back as not prime straight from the done state.
  `MRPT_ASSERT_NXT(a_small_not_prime, clk_i, rst_ni, in_valid_i && !in_stall_o && !out_valid_o && (n_i[WIDTH-1:1] == '0), ##1 (out_valid_o && !is_prime_o), "zero or one not rejected")

endmodule

bind miller_rabin_prime_test mrpt_checker #(
  .WIDTH(WIDTH)
) u_mrpt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .n_i        (n_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .is_prime_o (is_prime_o)
);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miller-Rabin prime test bench
// Sends test values through the valid/stall input channel and compares each
// returned verdict with a typed-in one or a software primality check over the same
// witness bases. A directed table comes first, then a mostly small random mix.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned WIDTH = mrpt_pkg::DEF_WIDTH;

  // Number of random items after the directed table.
  localparam int RANDOM_ITEMS = 80;

  // The fixed witness bases, tried in this order.
  localparam int NUM_WITNESSES = 9;
  localparam logic [63:0] WITNESSES [NUM_WITNESSES] = '{
    64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd19, 64'd23
  };

  // One row of the directed table. Where known is set, the verdict is typed
  // in by hand; otherwise the software check supplies it.
  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic             known;
    logic             verdict;
  } probe_t;

  localparam int NUM_PROBES = 22;

  // Extremes, the bases themselves, classic pseudoprimes, primes with a deep
  // power of two in n-1, and values at and past the exact range.
  localparam probe_t PROBES [NUM_PROBES] = '{
    '{62'd0, 1'b1, 1'b0},                      // below two
    '{62'd1, 1'b1, 1'b0},                      // below two
    '{62'd2, 1'b1, 1'b1},                      // smallest base
    '{62'd3, 1'b1, 1'b1},
    '{62'd4, 1'b1, 1'b0},                      // even, n-1 has no factor of two
    '{62'd9, 1'b1, 1'b0},
    '{62'd17, 1'b1, 1'b1},                     // equals a middle base
    '{62'd23, 1'b1, 1'b1},                     // equals the last base
    '{62'd24, 1'b1, 1'b0},
    '{62'd25, 1'b1, 1'b0},
    '{62'd29, 1'b1, 1'b1},                     // first prime past the bases
    '{62'd561, 1'b1, 1'b0},                    // Carmichael number
    '{62'd2047, 1'b1, 1'b0},                   // strong pseudoprime to base 2
    '{62'd65537, 1'b1, 1'b1},                  // n-1 is a power of two
    '{62'd998244353, 1'b1, 1'b1},              // n-1 = 119 * 2^23
    '{62'd3215031751, 1'b1, 1'b0},             // fools bases 2 through 7
    '{62'h1FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1},    // Mersenne prime 2^61-1
    '{62'd3825123056546413050, 1'b1, 1'b0},    // top of the exact range, even
    '{62'd3825123056546413051, 1'b0, 1'b0},    // first value past the range
    '{62'h3FFF_FFFF_FFFF_FFC7, 1'b0, 1'b0},
    '{62'h3FFF_FFFF_FFFF_FFFE, 1'b1, 1'b0},    // even, so base 2 rejects it
    '{62'h3FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0}     // all ones
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [WIDTH-1:0] n_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             is_prime_o;

  // Verdicts owed by the block, oldest first.
  logic pending_verdicts [$];

  int error_count     = 0;
  int items_sent      = 0;
  int verdicts_seen   = 0;
  int primes_reported = 0;
  int sender_quiet    = 0;
  int receiver_quiet  = 0;

  miller_rabin_prime_test #(
    .WIDTH(WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .n_i        (n_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .is_prime_o (is_prime_o)
  );

  // 4 ns clock period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // (a * b) mod m through a double-width product. The block reaches the same
  // value by shift-and-add, so only the residue has to agree.
  function automatic logic [63:0] modular_product(input logic [63:0] a, input logic [63:0] b,
                                                  input logic [63:0] m);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b};
    return 64'(wide % {64'd0, m});
  endfunction

  // base^e mod m by square and multiply.
  function automatic logic [63:0] modular_power(input logic [63:0] base, input logic [63:0] e,
                                                input logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] rest;
    acc  = 64'd1 % m;
    sq   = base % m;
    rest = e;
    while (rest != 64'd0) begin
      if (rest[0]) begin
        acc = modular_product(acc, sq, m);
      end
      sq   = modular_product(sq, sq, m);
      rest = rest >> 1;
    end
    return acc;
  endfunction

  // Strong probable-prime test over all nine bases. Squaring stops at r-1
  // steps, so n-1 reached only at exponent n-1 does not count as a pass.
  function automatic logic primality_verdict(input logic [WIDTH-1:0] n);
    logic [63:0] wide_n;
    logic [63:0] odd_part;
    logic [63:0] x;
    int unsigned twos;
    logic        passed;
    wide_n = 64'(n);
    if (wide_n < 64'd2) begin
      return 1'b0;
    end
    odd_part = wide_n - 64'd1;
    twos     = 0;
    while (odd_part[0] == 1'b0) begin
      odd_part = odd_part >> 1;
      twos++;
    end
    for (int i = 0; i < NUM_WITNESSES; i++) begin
      if (wide_n == WITNESSES[i]) begin
        return 1'b1;
      end
      x      = modular_power(WITNESSES[i], odd_part, wide_n);
      passed = (x == 64'd1) || (x == wide_n - 64'd1);
      for (int k = 1; k < twos && !passed; k++) begin
        x      = modular_product(x, x, wide_n);
        passed = (x == wide_n - 64'd1);
      end
      if (!passed) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Walks upward to the next value that the check calls prime; stops at the
  // top of the field if none is found on the way.
  function automatic logic [WIDTH-1:0] prime_at_or_above(input logic [WIDTH-1:0] start);
    logic [WIDTH-1:0] v;
    v = start;
    while (!primality_verdict(v) && v != '1) begin
      v++;
    end
    return v;
  endfunction

  // Draws a random idle gap before the next item. Now and then a side enters a
  // quiet stretch of eight items with no idling at all.
  function automatic int draw_pause(inout int quiet_run);
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      quiet_run = 8;
    end
    return $urandom_range(0, 8);
  endfunction

  // Presents one value after a random gap and holds it until the block takes
  // it. Called at a rising edge; returns at the edge that accepted the item.
  // Valid is lowered only when a gap follows, so it never drops and rises in
  // the same time step.
  task automatic offer_value(input logic [WIDTH-1:0] value, input logic verdict);
    int gap;
    gap = draw_pause(sender_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    n_i        <= value;
    do @(posedge clk_i); while (in_stall_o);
    pending_verdicts.push_back(verdict);
    items_sent++;
  endtask

  // Stimulus: reset, the directed table, a pause until the block drains, then
  // the random mix, and finally the wrap-up.
  initial begin
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] p;
    logic [WIDTH-1:0] q;
    int               kind;
    int               bits;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    n_i        = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_PROBES; i++) begin
      offer_value(PROBES[i].value,
                  PROBES[i].known ? PROBES[i].verdict : primality_verdict(PROBES[i].value));
    end

    // Hold off until every owed verdict is back, so the next item meets a
    // block that has been idle for a while.
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);

    // Run time grows with the bit length of n, so most random items are at
    // most 20 bits wide and only about one in twelve uses the full width.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        value = WIDTH'({$urandom, $urandom});
        kind  = $urandom_range(0, 2);
        if (kind == 1) begin
          value = prime_at_or_above(value | WIDTH'(1));
        end else if (kind == 2) begin
          // Product of two 31-bit primes: odd, large, and free of small factors.
          p     = prime_at_or_above(WIDTH'({1'b1, 30'($urandom)}));
          q     = prime_at_or_above(WIDTH'({1'b1, 30'($urandom)}));
          value = p * q;
        end
      end else begin
        bits  = $urandom_range(2, 20);
        value = WIDTH'($urandom) & ((WIDTH'(1) << bits) - WIDTH'(1));
        kind  = $urandom_range(0, 19);
        if (kind < 9) begin
          value = prime_at_or_above(value);
        end else if (kind < 14) begin
          value = value | WIDTH'(1);
        end
      end
      offer_value(value, primality_verdict(value));
    end
    in_valid_i <= 1'b0;

    // Every item gives exactly one verdict, so once the queue is empty only a
    // short tail is watched for stray results.
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $error("is_prime: %0d verdicts never arrived", pending_verdicts.size());
      error_count++;
    end

    $display("Sent %0d values (%0d from the directed table); %0d verdicts checked.",
             items_sent, NUM_PROBES, verdicts_seen);
    $display("The block reported %0d primes, with random idling on both channels.",
             primes_reported);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: stall for a random number of cycles, then take the next
  // verdict and compare it with the oldest one owed.
  initial begin
    int   hold;
    logic expected;

    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = draw_pause(receiver_quiet);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      verdicts_seen++;
      if (is_prime_o === 1'b1) begin
        primes_reported++;
      end
      if (pending_verdicts.size() == 0) begin
        $error("is_prime: result with no item outstanding, actual %0b", is_prime_o);
        error_count++;
      end else begin
        expected = pending_verdicts.pop_front();
        if (is_prime_o !== expected) begin
          $error("is_prime: expected %0b, actual %0b", expected, is_prime_o);
          error_count++;
        end
      end
    end
  end

  // Guard against a hang. A correct run needs less than a fifth of this
  // even if every item were a full-width prime.
  initial begin
    #200_000_000;
    $error("Run did not finish in time; %0d verdicts still owed", pending_verdicts.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
